FILE: rtl/sra_pkg.sv
package sra_pkg;

  localparam int ANGLE_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 30;

  // Q4.30 sines and cosines; sums keep 30 fraction bits
  localparam int FRAC     = 30;
  localparam int TRIG_W   = 34;
  localparam int NUM_W    = 36;
  // square root of a Q1.60 radicand, one result bit a step
  localparam int RAD_W    = 61;
  localparam int ROOT_W   = 31;
  localparam int SQ_STEPS = 31;
  localparam int SQ_W     = 63;

  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;

  localparam logic REG_LAT = 1'b0;
  localparam logic REG_LON = 1'b1;

  typedef struct packed {
    logic [31:0] gha;
    logic [31:0] lha;
  } sra_hour_t;

  typedef struct packed {
    sra_hour_t hour;
    logic      flip_d;
    logic      flip_l;
    logic      flip_h;
  } sra_rot_tag_t;

  typedef struct packed {
    sra_hour_t          hour;
    logic signed [31:0] s;
    logic signed [35:0] n;
  } sra_alt_tag_t;

  typedef struct packed {
    sra_hour_t          hour;
    logic [30:0]        c;
    logic signed [31:0] s;
    logic signed [31:0] ncl;
    logic               deg;
  } sra_azi_tag_t;

  typedef struct packed {
    sra_hour_t hour;
    logic      deg;
    logic      base;
  } sra_vec_tag_t;

  function automatic logic [63:0] mul_high(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid;
    al  = {32'd0, a[31:0]};
    ah  = {32'd0, a[63:32]};
    bl  = {32'd0, b[31:0]};
    bh  = {32'd0, b[63:32]};
    ll  = al * bl;
    lh  = al * bh;
    hl  = ah * bl;
    hh  = ah * bh;
    mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
    return hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
  endfunction

  // restoring division, one quotient bit a step
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r    = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctangent of 2^-idx as a binary angle of ab bits, rounded to nearest
  function automatic logic [63:0] atan_entry(input int idx, input int ab);
    logic [63:0] acc;
    logic [63:0] term;
    logic [63:0] t;
    int          p;
    acc = '0;
    t   = '0;
    if (idx == 0) begin
      t = 64'd1 << (ab - 3);
    end else begin
      for (int k = 0; k < 63; k++) begin
        p = idx * (2 * k + 1);
        if (p <= 62) begin
          term = udiv(64'd1 << (62 - p), 64'(2 * k + 1));
          if ((k & 1) == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      t = mul_high(acc, INV_TWO_PI_Q64);
      t = (t + (64'd1 << (61 - ab))) >> (62 - ab);
    end
    return t;
  endfunction

  // reciprocal of the rotation gain, Q2.30
  function automatic longint inv_gain(input int ab, input int stages);
    longint x, y, z, dx, dy, a;
    x = longint'(1) <<< FRAC;
    y = 0;
    z = 0;
    for (int i = 0; i < stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      a  = longint'(atan_entry(i, ab));
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - a;
      end else begin
        x = x + dx; y = y - dy; z = z + a;
      end
    end
    return longint'(udiv((64'd1 << (2 * FRAC)) + 64'(x >>> 1), 64'(x)));
  endfunction

  function automatic logic [63:0] to_internal(input logic [31:0] u, input int ab);
    return {u, 32'd0} >> (64 - ab);
  endfunction

  // round half up to 32 bits, modulo one turn
  function automatic logic [31:0] to_field(input logic [63:0] a, input int ab);
    logic [63:0] w;
    w = (a << (64 - ab)) + 64'h0000_0000_8000_0000;
    return w[63:32];
  endfunction

endpackage

FILE: rtl/sight_reduction_alt_az.sv
// Channel     Ports                                       Handshake
// sight in    object_ra_i, object_dec_i, mean_sidereal_i  start, busy (never high)
// result out  greenwich_hour_angle_o .. degenerate_o      result_valid_o, one cycle
// config      psel, penable, pwrite, paddr, pwdata        APB, pready always high
//
// A sight is taken every cycle; its result passes through the two CORDIC
// pipelines and the two 31-step square roots.
// Reset clears the observer registers and all valid bits.
// Nothing stalls: the result strobe lasts one cycle and must be taken.
module sight_reduction_alt_az #(
  parameter int ANGLE_BITS    = sra_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = sra_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        object_ra_i,
  input  logic signed [31:0] object_dec_i,
  input  logic [31:0]        mean_sidereal_i,
  output logic               result_valid_o,
  output logic [31:0]        greenwich_hour_angle_o,
  output logic [31:0]        local_hour_angle_o,
  output logic signed [31:0] computed_altitude_o,
  output logic [31:0]        computed_azimuth_o,
  output logic               degenerate_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AB   = ANGLE_BITS;
  localparam int ZW   = AB + 2;
  localparam int W    = sra_pkg::TRIG_W;
  localparam int FRAC = sra_pkg::FRAC;
  localparam longint INV_GAIN = sra_pkg::inv_gain(AB, CORDIC_STAGES);
  localparam logic signed [W-1:0] X0 = W'(INV_GAIN);
  localparam logic signed [72:0] ONE_S = 73'sd1 <<< FRAC;

  // configuration
  logic [31:0] lat_q, lon_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign wr_en  = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == sra_pkg::REG_LON) ? lon_q : lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
      lon_q <= '0;
    end else if (wr_en) begin
      if (paddr[2] == sra_pkg::REG_LAT) lat_q <= pwdata;
      else lon_q <= pwdata;
    end
  end

  // valid bits of the stages held in this module
  logic v1_q, v2_q, vp_q, vm1_q, vm2_q, vm3_q, vm4_q, vm5_q, vv1_q, vv2_q, vv3_q, vv4_q;
  logic vr_q;
  logic rot_v, alt_v, azi_v, vec_v;

  // T1: hour angles and internal angles
  sra_pkg::sra_hour_t hour1_q;
  logic [AB-1:0]      adec1_q, alat1_q, alha1_q;
  logic [31:0]        gha_c, lha_c;

  assign gha_c = mean_sidereal_i - object_ra_i;
  assign lha_c = gha_c + lon_q;

  always_ff @(posedge clk_i) begin
    hour1_q.gha <= gha_c;
    hour1_q.lha <= lha_c;
    adec1_q     <= AB'(sra_pkg::to_internal(object_dec_i, AB));
    alat1_q     <= AB'(sra_pkg::to_internal(lat_q, AB));
    alha1_q     <= AB'(sra_pkg::to_internal(lha_c, AB));
  end

  // T2: fold into the right half plane
  sra_pkg::sra_rot_tag_t rtag2_q, rtag_o;
  logic signed [ZW-1:0]  zd2_q, zl2_q, zh2_q;

  always_ff @(posedge clk_i) begin
    logic          fd, fl, fh;
    logic [AB-1:0] ad, al, ah;
    fd = adec1_q[AB-1] ^ adec1_q[AB-2];
    fl = alat1_q[AB-1] ^ alat1_q[AB-2];
    fh = alha1_q[AB-1] ^ alha1_q[AB-2];
    ad = {adec1_q[AB-1] ^ fd, adec1_q[AB-2:0]};
    al = {alat1_q[AB-1] ^ fl, alat1_q[AB-2:0]};
    ah = {alha1_q[AB-1] ^ fh, alha1_q[AB-2:0]};
    zd2_q <= {{2{ad[AB-1]}}, ad};
    zl2_q <= {{2{al[AB-1]}}, al};
    zh2_q <= {{2{ah[AB-1]}}, ah};
    rtag2_q.hour   <= hour1_q;
    rtag2_q.flip_d <= fd;
    rtag2_q.flip_l <= fl;
    rtag2_q.flip_h <= fh;
  end

  logic signed [W-1:0] xd, yd, xl, yl, xh;
  logic [$bits(sra_pkg::sra_rot_tag_t)-1:0] rtag_bits;

  sra_cordic #(.ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .VECTOR(1'b0),
               .TAG_W($bits(sra_pkg::sra_rot_tag_t))) u_rot_dec (
    .clk_i, .rst_ni, .valid_i(v2_q), .x_i(X0), .y_i('0), .z_i(zd2_q),
    .tag_i(rtag2_q), .valid_o(rot_v), .x_o(xd), .y_o(yd), .z_o(), .tag_o(rtag_bits)
  );

  sra_cordic #(.ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_lat (
    .clk_i, .rst_ni, .valid_i(v2_q), .x_i(X0), .y_i('0), .z_i(zl2_q),
    .tag_i(1'b0), .valid_o(), .x_o(xl), .y_o(yl), .z_o(), .tag_o()
  );

  sra_cordic #(.ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .VECTOR(1'b0), .TAG_W(1)) u_rot_lha (
    .clk_i, .rst_ni, .valid_i(v2_q), .x_i(X0), .y_i('0), .z_i(zh2_q),
    .tag_i(1'b0), .valid_o(), .x_o(xh), .y_o(), .z_o(), .tag_o()
  );

  assign rtag_o = sra_pkg::sra_rot_tag_t'(rtag_bits);

  // P: undo the half-turn fold
  logic signed [W-1:0] cd_q, sd_q, cl_q, sl_q, ch_q;
  sra_pkg::sra_hour_t  hourp_q;

  always_ff @(posedge clk_i) begin
    cd_q    <= rtag_o.flip_d ? -xd : xd;
    sd_q    <= rtag_o.flip_d ? -yd : yd;
    cl_q    <= rtag_o.flip_l ? -xl : xl;
    sl_q    <= rtag_o.flip_l ? -yl : yl;
    ch_q    <= rtag_o.flip_h ? -xh : xh;
    hourp_q <= rtag_o.hour;
  end

  // M1..M5: spherical products, clamp, radicand of cos Hc
  logic signed [2*W-1:0] p1_q, p2_q, p3_q, p4_q, p1b_q, p3b_q;
  logic signed [W-1:0]   ch1_q;
  logic signed [71:0]    q2_q, q4_q;
  logic signed [31:0]    s3_q, s4_q, s5_q;
  logic signed [35:0]    n3_q, n4_q, n5_q;
  logic [63:0]           ss4_q;
  logic [sra_pkg::RAD_W-1:0] rad5_q;
  sra_pkg::sra_hour_t    hm1_q, hm2_q, hm3_q, hm4_q, hm5_q;

  always_ff @(posedge clk_i) begin
    logic signed [72:0] sum, dif;
    logic signed [63:0] sq;
    p1_q  <= sd_q * sl_q;
    p2_q  <= cd_q * cl_q;
    p3_q  <= sd_q * cl_q;
    p4_q  <= cd_q * sl_q;
    ch1_q <= ch_q;
    hm1_q <= hourp_q;

    q2_q  <= 38'(p2_q >>> FRAC) * ch1_q;
    q4_q  <= 38'(p4_q >>> FRAC) * ch1_q;
    p1b_q <= p1_q;
    p3b_q <= p3_q;
    hm2_q <= hm1_q;

    sum = (73'(p1b_q) + 73'(q2_q)) >>> FRAC;
    dif = (73'(p3b_q) - 73'(q4_q)) >>> FRAC;
    if (sum > ONE_S) s3_q <= 32'(ONE_S);
    else if (sum < -ONE_S) s3_q <= 32'(-ONE_S);
    else s3_q <= 32'(sum);
    n3_q  <= 36'(dif);
    hm3_q <= hm2_q;

    sq     = 64'(s3_q) * 64'(s3_q);
    ss4_q <= sq;
    s4_q  <= s3_q;
    n4_q  <= n3_q;
    hm4_q <= hm3_q;

    rad5_q <= sra_pkg::RAD_W'((64'd1 << (2 * FRAC)) - ss4_q);
    s5_q   <= s4_q;
    n5_q   <= n4_q;
    hm5_q  <= hm4_q;
  end

  sra_pkg::sra_alt_tag_t atag_in, atag_o;
  logic [$bits(sra_pkg::sra_alt_tag_t)-1:0] atag_bits;
  logic [sra_pkg::ROOT_W-1:0] c_root;

  assign atag_in.hour = hm5_q;
  assign atag_in.s    = s5_q;
  assign atag_in.n    = n5_q;

  sra_isqrt #(.TAG_W($bits(sra_pkg::sra_alt_tag_t))) u_sqrt_cos (
    .clk_i, .rst_ni, .valid_i(vm5_q), .rad_i(rad5_q), .tag_i(atag_in),
    .valid_o(alt_v), .root_o(c_root), .tag_o(atag_bits)
  );

  assign atag_o = sra_pkg::sra_alt_tag_t'(atag_bits);

  // V1..V3: clamp the azimuth numerator, radicand of the second leg
  sra_pkg::sra_azi_tag_t v1t_q, v2t_q, v3t_q, ztag_o;
  logic [61:0]           cc2_q;
  logic [63:0]           nn2_q;
  logic [sra_pkg::RAD_W-1:0] rad3_q;

  always_ff @(posedge clk_i) begin
    logic signed [35:0] cs;
    logic signed [63:0] nsq;
    cs = signed'({5'd0, c_root});
    v1t_q.hour <= atag_o.hour;
    v1t_q.c    <= c_root;
    v1t_q.s    <= atag_o.s;
    v1t_q.deg  <= (c_root == '0);
    if (atag_o.n > cs) v1t_q.ncl <= 32'(cs);
    else if (atag_o.n < -cs) v1t_q.ncl <= 32'(-cs);
    else v1t_q.ncl <= 32'(atag_o.n);

    nsq    = 64'(v1t_q.ncl) * 64'(v1t_q.ncl);
    cc2_q <= 62'(v1t_q.c) * 62'(v1t_q.c);
    nn2_q <= nsq;
    v2t_q <= v1t_q;

    rad3_q <= sra_pkg::RAD_W'(64'(cc2_q) - nn2_q);
    v3t_q  <= v2t_q;
  end

  logic [$bits(sra_pkg::sra_azi_tag_t)-1:0] ztag_bits;
  logic [sra_pkg::ROOT_W-1:0] y_root;

  sra_isqrt #(.TAG_W($bits(sra_pkg::sra_azi_tag_t))) u_sqrt_azi (
    .clk_i, .rst_ni, .valid_i(vv3_q), .rad_i(rad3_q), .tag_i(v3t_q),
    .valid_o(azi_v), .root_o(y_root), .tag_o(ztag_bits)
  );

  assign ztag_o = sra_pkg::sra_azi_tag_t'(ztag_bits);

  // V4: vectoring inputs; a negative numerator is reflected through the origin
  logic signed [W-1:0]   hx4_q, hy4_q, zx4_q, zy4_q;
  sra_pkg::sra_vec_tag_t vt4_q, vt_o;

  always_ff @(posedge clk_i) begin
    logic signed [W-1:0] nx, ny;
    nx = W'(ztag_o.ncl);
    ny = signed'(W'(y_root));
    hx4_q <= signed'(W'(ztag_o.c));
    hy4_q <= W'(ztag_o.s);
    zx4_q <= ztag_o.ncl[31] ? -nx : nx;
    zy4_q <= ztag_o.ncl[31] ? -ny : ny;
    vt4_q.hour <= ztag_o.hour;
    vt4_q.deg  <= ztag_o.deg;
    vt4_q.base <= ztag_o.ncl[31];
  end

  logic signed [ZW-1:0] z_hc, z_zn;
  logic [$bits(sra_pkg::sra_vec_tag_t)-1:0] vtag_bits;

  sra_cordic #(.ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .VECTOR(1'b1), .TAG_W(1)) u_vec_alt (
    .clk_i, .rst_ni, .valid_i(vv4_q), .x_i(hx4_q), .y_i(hy4_q), .z_i('0),
    .tag_i(1'b0), .valid_o(), .x_o(), .y_o(), .z_o(z_hc), .tag_o()
  );

  sra_cordic #(.ANGLE_BITS(AB), .STAGES(CORDIC_STAGES), .VECTOR(1'b1),
               .TAG_W($bits(sra_pkg::sra_vec_tag_t))) u_vec_azi (
    .clk_i, .rst_ni, .valid_i(vv4_q), .x_i(zx4_q), .y_i(zy4_q), .z_i('0),
    .tag_i(vt4_q), .valid_o(vec_v), .x_o(), .y_o(), .z_o(z_zn), .tag_o(vtag_bits)
  );

  assign vt_o = sra_pkg::sra_vec_tag_t'(vtag_bits);

  // output register
  logic [31:0] gha_q, lha_q, hc_q, zn_q;
  logic        deg_q;

  always_ff @(posedge clk_i) begin
    logic [AB-1:0] za, zm, ha;
    ha = z_hc[AB-1:0];
    za = z_zn[AB-1:0] + {vt_o.base, {(AB-1){1'b0}}};
    // mirror when the hour angle lies in the first half turn
    zm = vt_o.hour.lha[31] ? za : -za;
    if (vt_o.deg) zm = '0;
    gha_q <= vt_o.hour.gha;
    lha_q <= vt_o.hour.lha;
    hc_q  <= sra_pkg::to_field(64'(ha), AB);
    zn_q  <= sra_pkg::to_field(64'(zm), AB);
    deg_q <= vt_o.deg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; vp_q <= 1'b0;
      vm1_q <= 1'b0; vm2_q <= 1'b0; vm3_q <= 1'b0; vm4_q <= 1'b0; vm5_q <= 1'b0;
      vv1_q <= 1'b0; vv2_q <= 1'b0; vv3_q <= 1'b0; vv4_q <= 1'b0;
      vr_q <= 1'b0;
    end else begin
      v1_q  <= start && !busy;
      v2_q  <= v1_q;
      vp_q  <= rot_v;
      vm1_q <= vp_q;
      vm2_q <= vm1_q;
      vm3_q <= vm2_q;
      vm4_q <= vm3_q;
      vm5_q <= vm4_q;
      vv1_q <= alt_v;
      vv2_q <= vv1_q;
      vv3_q <= vv2_q;
      vv4_q <= azi_v;
      vr_q  <= vec_v;
    end
  end

  assign result_valid_o         = vr_q;
  assign greenwich_hour_angle_o = gha_q;
  assign local_hour_angle_o     = lha_q;
  assign computed_altitude_o    = signed'(hc_q);
  assign computed_azimuth_o     = zn_q;
  assign degenerate_o           = deg_q;

endmodule

FILE: rtl/sra_cordic.sv
module sra_cordic #(
  parameter int ANGLE_BITS = sra_pkg::ANGLE_BITS_DEF,
  parameter int STAGES     = sra_pkg::CORDIC_STAGES_DEF,
  parameter bit VECTOR     = 1'b0,
  parameter int TAG_W      = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [sra_pkg::TRIG_W-1:0] x_i,
  input  logic signed [sra_pkg::TRIG_W-1:0] y_i,
  input  logic signed [ANGLE_BITS+1:0]      z_i,
  input  logic [TAG_W-1:0]            tag_i,
  output logic                        valid_o,
  output logic signed [sra_pkg::TRIG_W-1:0] x_o,
  output logic signed [sra_pkg::TRIG_W-1:0] y_o,
  output logic signed [ANGLE_BITS+1:0]      z_o,
  output logic [TAG_W-1:0]            tag_o
);

  localparam int W  = sra_pkg::TRIG_W;
  localparam int ZW = ANGLE_BITS + 2;

  logic signed [ZW-1:0] atan_c [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_atan
    localparam logic [63:0] AFULL = sra_pkg::atan_entry(g, ANGLE_BITS);
    assign atan_c[g] = AFULL[ZW-1:0];
  end

  logic                v_q   [STAGES];
  logic signed [W-1:0] x_q   [STAGES];
  logic signed [W-1:0] y_q   [STAGES];
  logic signed [ZW-1:0] z_q  [STAGES];
  logic [TAG_W-1:0]    tag_q [STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < STAGES; i++) v_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < STAGES; i++) v_q[i] <= (i == 0) ? valid_i : v_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [W-1:0]  xa, ya, dx, dy;
    logic signed [ZW-1:0] za;
    logic                 up;
    for (int i = 0; i < STAGES; i++) begin
      if (i == 0) begin
        xa = x_i; ya = y_i; za = z_i;
        tag_q[i] <= tag_i;
      end else begin
        xa = x_q[i-1]; ya = y_q[i-1]; za = z_q[i-1];
        tag_q[i] <= tag_q[i-1];
      end
      dx = ya >>> i;
      dy = xa >>> i;
      // rotate towards z = 0, or towards y = 0 when vectoring
      up = VECTOR ? ya[W-1] : !za[ZW-1];
      if (up) begin
        x_q[i] <= xa - dx; y_q[i] <= ya + dy; z_q[i] <= za - atan_c[i];
      end else begin
        x_q[i] <= xa + dx; y_q[i] <= ya - dy; z_q[i] <= za + atan_c[i];
      end
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign x_o     = x_q[STAGES-1];
  assign y_o     = y_q[STAGES-1];
  assign z_o     = z_q[STAGES-1];
  assign tag_o   = tag_q[STAGES-1];

endmodule

FILE: rtl/sra_isqrt.sv
module sra_isqrt #(
  parameter int TAG_W = 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [sra_pkg::RAD_W-1:0]    rad_i,
  input  logic [TAG_W-1:0]             tag_i,
  output logic                         valid_o,
  output logic [sra_pkg::ROOT_W-1:0]   root_o,
  output logic [TAG_W-1:0]             tag_o
);

  localparam int N  = sra_pkg::SQ_STEPS;
  localparam int SW = sra_pkg::SQ_W;

  logic          v_q   [N];
  logic [SW-1:0] n_q   [N];
  logic [SW-1:0] r_q   [N];
  logic [TAG_W-1:0] tag_q [N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) v_q[i] <= 1'b0;
    end else begin
      for (int i = 0; i < N; i++) v_q[i] <= (i == 0) ? valid_i : v_q[i-1];
    end
  end

  // one result bit a stage, trial bit walking down two places each step
  always_ff @(posedge clk_i) begin
    logic [SW-1:0] na, ra, b;
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        na = SW'(rad_i); ra = '0;
        tag_q[i] <= tag_i;
      end else begin
        na = n_q[i-1]; ra = r_q[i-1];
        tag_q[i] <= tag_q[i-1];
      end
      b = SW'(1) << (sra_pkg::RAD_W - 1 - 2 * i);
      if (na >= ra + b) begin
        n_q[i] <= na - (ra + b);
        r_q[i] <= (ra >> 1) + b;
      end else begin
        n_q[i] <= na;
        r_q[i] <= ra >> 1;
      end
    end
  end

  assign valid_o = v_q[N-1];
  assign root_o  = r_q[N-1][sra_pkg::ROOT_W-1:0];
  assign tag_o   = tag_q[N-1];

endmodule
